// ----- src/gm2g_pkg.sv -----
// Shared constants, payload types, register codes and the exp(-t) table for the 2-D Gaussian block
package gm2g_pkg;

  // Number format and table size
  localparam int FRAC_BITS         = 16;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int DATA_W            = 32;
  localparam int ADDR_W            = 5;

  // |arg| below 4.0 needs FRAC_BITS+2 bits
  localparam int AMAG_W    = FRAC_BITS + 2;
  localparam int IDX_W     = $clog2(EXP_TABLE_ENTRIES);
  localparam int ARG_STEPS = AMAG_W;
  localparam int ARG_LAT   = ARG_STEPS + 1;
  localparam int EXP_LAT   = 4;
  // numerator 2*|h|*|arg|: |h| < 2^32
  localparam int NUM_W     = DATA_W + 1 + AMAG_W;
  localparam int DDIV_LAT  = NUM_W;
  localparam int LO_W      = NUM_W / 2;
  localparam int HI_W      = NUM_W - LO_W;
  localparam int PIPE_LAT  = ARG_LAT + EXP_LAT + 3 + DDIV_LAT + 2;
  localparam int PACK_W    = 96;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SAT        = 2'd1;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

  // Register indexes (byte address = 4*index)
  typedef enum logic [2:0] {
    REG_CENTRE_U  = 3'd0,
    REG_CENTRE_V  = 3'd1,
    REG_WIDTH_U   = 3'd2,
    REG_WIDTH_V   = 3'd3,
    REG_AMPLITUDE = 3'd4,
    REG_OFFSET    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] centre_u;
    logic signed [DATA_W-1:0] centre_v;
    logic signed [DATA_W-1:0] width_u;
    logic signed [DATA_W-1:0] width_v;
    logic signed [DATA_W-1:0] amplitude;
    logic signed [DATA_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] d_centre_u;
    logic signed [DATA_W-1:0] d_centre_v;
    logic signed [DATA_W-1:0] d_width_u;
    logic signed [DATA_W-1:0] d_width_v;
    logic signed [DATA_W-1:0] d_amplitude;
    logic signed [DATA_W-1:0] d_u;
    logic signed [DATA_W-1:0] d_v;
    logic        [1:0]        status;
  } out_req_t;

  typedef logic [31:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

  // exp(-t) samples in unsigned Q1.31 over t in [0,16]
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] e;
    longint      sum;
    x    = 64'(64'd1 << 35) / EXP_TABLE_ENTRIES;
    term = 64'd1 << 31;
    sum  = longint'(64'd1 << 31);
    // alternating Taylor series for the per-step ratio
    for (int k = 1; k <= 30; k++) begin
      term = ((term * x) >> 31) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e      = 64'd1 << 31;
    tab[0] = e[31:0];
    for (int i = 1; i <= EXP_TABLE_ENTRIES; i++) begin
      e      = (e * 64'(sum) + (64'd1 << 30)) >> 31;
      tab[i] = e[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Signed saturation of a sign/magnitude pair; returns {saturated, value}
  function automatic logic [DATA_W:0] sat_pack(input logic neg, input logic [PACK_W-1:0] mag);
    logic [PACK_W-1:0] lim;
    logic              sat;
    logic [PACK_W-1:0] m;
    lim = neg ? (PACK_W'(1) << (DATA_W - 1)) : ((PACK_W'(1) << (DATA_W - 1)) - PACK_W'(1));
    sat = mag > lim;
    m   = sat ? lim : mag;
    return {sat, (neg ? DATA_W'(-m) : DATA_W'(m))};
  endfunction

endpackage

// ----- src/gm2g_regs.sv -----
// Configuration register bank behind the APB-style port
module gm2g_regs import gm2g_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes; byte lane bits of the address are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_u  <= '0;
      cfg.centre_v  <= '0;
      cfg.width_u   <= DATA_W'(1) << FRAC_BITS;
      cfg.width_v   <= DATA_W'(1) << FRAC_BITS;
      cfg.amplitude <= DATA_W'(1) << FRAC_BITS;
      cfg.offset    <= '0;
    end else if (wr) begin
      case (idx)
        REG_CENTRE_U:  cfg.centre_u  <= pwdata;
        REG_CENTRE_V:  cfg.centre_v  <= pwdata;
        REG_WIDTH_U:   cfg.width_u   <= pwdata;
        REG_WIDTH_V:   cfg.width_v   <= pwdata;
        REG_AMPLITUDE: cfg.amplitude <= pwdata;
        REG_OFFSET:    cfg.offset    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_CENTRE_U:  prdata = cfg.centre_u;
      REG_CENTRE_V:  prdata = cfg.centre_v;
      REG_WIDTH_U:   prdata = cfg.width_u;
      REG_WIDTH_V:   prdata = cfg.width_v;
      REG_AMPLITUDE: prdata = cfg.amplitude;
      REG_OFFSET:    prdata = cfg.offset;
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/gm2g_arg.sv -----
// Normalized distance |pos-centre|/|width| per axis: one quotient bit per stage
module gm2g_arg import gm2g_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [DATA_W-1:0] pos,
  input  logic signed [DATA_W-1:0] cen,
  input  logic signed [DATA_W-1:0] wid,
  output logic        [AMAG_W-1:0] amag,
  output logic                     aneg,
  output logic                     far
);

  logic signed [DATA_W:0]   d;
  logic        [DATA_W:0]   dmag;
  logic        [DATA_W-1:0] wmag;
  logic                     far0;

  logic [DATA_W:0]   rem  [0:ARG_STEPS];
  logic [AMAG_W-1:0] nlow [0:ARG_STEPS];
  logic [AMAG_W-1:0] quo  [0:ARG_STEPS];
  logic              sgn  [0:ARG_STEPS];
  logic              farr [0:ARG_STEPS];

  // Difference, magnitudes and range check (quotient of 4.0 or more means far)
  always_comb begin
    d    = {pos[DATA_W-1], pos} - {cen[DATA_W-1], cen};
    dmag = d[DATA_W] ? (DATA_W+1)'(-d) : (DATA_W+1)'(d);
    wmag = wid[DATA_W-1] ? DATA_W'(-wid) : DATA_W'(wid);
    far0 = {1'b0, dmag} >= {wmag, 2'b00};
  end

  // Entry stage: top of the shifted dividend goes into the remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= dmag >> 2;
      nlow[0] <= {dmag[1:0], FRAC_BITS'(0)};
      quo[0]  <= '0;
      sgn[0]  <= d[DATA_W] != wid[DATA_W-1];
      farr[0] <= far0;
    end
  end

  // Restoring division steps
  for (genvar s = 1; s <= ARG_STEPS; s++) begin : g_step
    logic [DATA_W+1:0] trial;
    logic              ge;
    always_comb begin
      trial = {rem[s-1], nlow[s-1][AMAG_W-1]};
      ge    = trial >= {2'b00, wmag};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s]  <= ge ? (DATA_W+1)'(trial - {2'b00, wmag}) : trial[DATA_W:0];
        nlow[s] <= nlow[s-1] << 1;
        quo[s]  <= {quo[s-1][AMAG_W-2:0], ge};
        sgn[s]  <= sgn[s-1];
        farr[s] <= farr[s-1];
      end
    end
  end

  assign amag = farr[ARG_STEPS] ? '0 : quo[ARG_STEPS];
  assign aneg = sgn[ARG_STEPS];
  assign far  = farr[ARG_STEPS];

endmodule

// ----- src/gm2g_exp.sv -----
// exp(-arg^2) in Q1.31: square, table lookup, interpolation
module gm2g_exp import gm2g_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [AMAG_W-1:0] amag,
  input  logic              far,
  output logic [31:0]       ex
);

  localparam int T_W    = 2 * AMAG_W;
  localparam int TQ_SHR = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
  localparam int TQ_SHL = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;

  logic [T_W-1:0]   t;
  logic             far1, far2, far3;
  logic [35:0]      tq;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx1;
  logic [31:0]      f, ta, tb;
  logic [31:0]      a2, diff2, f2;
  logic [31:0]      a3, corr3;
  logic [63:0]      prod;

  // Stage 1: square
  always_ff @(posedge clk) begin
    if (adv) begin
      t    <= amag * amag;
      far1 <= far;
    end
  end

  // Stage 2: t in Q32, table index and fraction
  always_comb begin
    tq   = 36'(t >> TQ_SHR) << TQ_SHL;
    idx  = tq[35 -: IDX_W];
    idx1 = {1'b0, idx} + (IDX_W+1)'(1);
    f    = 32'(tq << (IDX_W - 4));
    ta   = EXP_TAB[idx];
    tb   = EXP_TAB[idx1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2    <= ta;
      diff2 <= (tb > ta) ? 32'd0 : ta - tb;
      f2    <= f;
      far2  <= far1;
    end
  end

  // Stage 3: interpolation product
  assign prod = diff2 * f2;

  always_ff @(posedge clk) begin
    if (adv) begin
      a3    <= a2;
      corr3 <= prod[63:32];
      far3  <= far2;
    end
  end

  // Stage 4: result, zero when far from centre
  always_ff @(posedge clk) begin
    if (adv) begin
      ex <= far3 ? 32'd0 : a3 - corr3;
    end
  end

endmodule

// ----- src/gm2g_ddiv.sv -----
// Pipelined restoring divider for the centre derivatives: one quotient bit per stage
module gm2g_ddiv import gm2g_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [NUM_W-1:0]  num,
  input  logic [DATA_W-1:0] den,
  output logic [NUM_W-1:0]  quo
);

  logic [DATA_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0]  nsh [0:NUM_W];
  logic [NUM_W-1:0]  qs  [0:NUM_W];

  assign rem[0] = '0;
  assign nsh[0] = num;
  assign qs[0]  = '0;

  for (genvar s = 1; s <= NUM_W; s++) begin : g_step
    logic [DATA_W:0] trial;
    logic            ge;
    always_comb begin
      trial = {rem[s-1], nsh[s-1][NUM_W-1]};
      ge    = trial >= {1'b0, den};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s] <= ge ? DATA_W'(trial - {1'b0, den}) : trial[DATA_W-1:0];
        nsh[s] <= nsh[s-1] << 1;
        qs[s]  <= {qs[s-1][NUM_W-2:0], ge};
      end
    end
  end

  assign quo = qs[NUM_W];

endmodule

// ----- src/gaussian_2d_model_gradient_top.sv -----
// Top level: 2-D Gaussian model value and gradient, fully pipelined
//
// Takes one sample point (u,v) per clock unless stalled and returns, per point, the model value
// amplitude*exp(-au^2)*exp(-av^2)+offset and its partial derivatives, all signed
// Q16.16 with saturation. Throughput is one point per cycle when not stalled; most
// of the pipeline lies in the two restoring dividers: the argument divider (one
// range stage plus 18 quotient stages) and the derivative divider (51 quotient
// stages). A stall on the output freezes the whole pipeline while a result waits.
// Write the model registers only while no point is in flight; width zero gives
// all-zero results with status 2.
module gaussian_2d_model_gradient_top import gm2g_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic [AMAG_W-1:0] amag_u;
    logic              aneg_u;
    logic [AMAG_W-1:0] amag_v;
    logic              aneg_v;
  } axis_t;

  typedef struct packed {
    axis_t             ax;
    logic [DATA_W-1:0] value;
    logic              vsat;
    logic [DATA_W-1:0] dam;
  } side_t;

  cfg_t              cfg;
  logic              adv;
  logic [PIPE_LAT-1:0] vld;

  logic [AMAG_W-1:0] amag_u, amag_v;
  logic              aneg_u, aneg_v, far_u, far_v;
  logic [31:0]       ex_u, ex_v;
  axis_t             ax_d [0:EXP_LAT-1];

  logic [63:0]       gprod;
  logic [31:0]       g_g, g_h;
  axis_t             ax_g, ax_h;
  logic [DATA_W-1:0] amp_mag, wmag_u, wmag_v;
  logic [63:0]       hprod;
  logic [DATA_W-1:0] hmag;
  logic              hneg, wneg_u, wneg_v, wz;

  logic signed [DATA_W+1:0] hs, sval;
  logic [DATA_W+1:0]        smag;
  logic [DATA_W:0]          vpack;
  logic [NUM_W-1:0]         num_u, num_v, dc_u, dc_v;
  side_t                    side_v;
  side_t                    side_q [0:DDIV_LAT-1];

  side_t                       side_m;
  logic [NUM_W-1:0]            dcm_u, dcm_v;
  logic [LO_W+AMAG_W-1:0]      plo_u, plo_v;
  logic [HI_W+AMAG_W-1:0]      phi_u, phi_v;
  logic [NUM_W+AMAG_W:0]       dwf_u, dwf_v;
  logic                        dneg_u, dneg_v;
  logic [DATA_W:0]             p_cu, p_cv, p_wu, p_wv, p_du, p_dv;
  logic                        any_sat;

  // Flow control: everything advances unless the result register is held
  assign adv       = !vld[PIPE_LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  gm2g_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Normalized distances
  gm2g_arg u_arg_u (
    .clk(clk), .adv(adv), .pos(in_data.u), .cen(cfg.centre_u), .wid(cfg.width_u),
    .amag(amag_u), .aneg(aneg_u), .far(far_u)
  );
  gm2g_arg u_arg_v (
    .clk(clk), .adv(adv), .pos(in_data.v), .cen(cfg.centre_v), .wid(cfg.width_v),
    .amag(amag_v), .aneg(aneg_v), .far(far_v)
  );

  // Exponentials
  gm2g_exp u_exp_u (.clk(clk), .adv(adv), .amag(amag_u), .far(far_u), .ex(ex_u));
  gm2g_exp u_exp_v (.clk(clk), .adv(adv), .amag(amag_v), .far(far_v), .ex(ex_v));

  // Axis data rides alongside the exp pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_d[0] <= '{amag_u: amag_u, aneg_u: aneg_u, amag_v: amag_v, aneg_v: aneg_v};
      for (int i = 1; i < EXP_LAT; i++) begin
        ax_d[i] <= ax_d[i-1];
      end
    end
  end

  // Stage G: product of the two exponentials
  assign gprod = ex_u * ex_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_g  <= 32'(gprod >> 31);
      ax_g <= ax_d[EXP_LAT-1];
    end
  end

  // Stage H: scale by |amplitude|
  always_comb begin
    hneg    = cfg.amplitude[DATA_W-1];
    amp_mag = hneg ? DATA_W'(-cfg.amplitude) : DATA_W'(cfg.amplitude);
    hprod   = amp_mag * g_g;
    wneg_u  = cfg.width_u[DATA_W-1];
    wneg_v  = cfg.width_v[DATA_W-1];
    wmag_u  = wneg_u ? DATA_W'(-cfg.width_u) : DATA_W'(cfg.width_u);
    wmag_v  = wneg_v ? DATA_W'(-cfg.width_v) : DATA_W'(cfg.width_v);
    wz      = (cfg.width_u == '0) || (cfg.width_v == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hmag <= DATA_W'(hprod >> 31);
      g_h  <= g_g;
      ax_h <= ax_g;
    end
  end

  // Stage V: model value and derivative numerators
  always_comb begin
    hs    = hneg ? -$signed({2'b00, hmag}) : $signed({2'b00, hmag});
    sval  = hs + $signed({{2{cfg.offset[DATA_W-1]}}, cfg.offset});
    smag  = sval[DATA_W+1] ? (DATA_W+2)'(-sval) : (DATA_W+2)'(sval);
    vpack = sat_pack(sval[DATA_W+1], PACK_W'(smag));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_u        <= NUM_W'({hmag, 1'b0} * ax_h.amag_u);
      num_v        <= NUM_W'({hmag, 1'b0} * ax_h.amag_v);
      side_v.ax    <= ax_h;
      side_v.value <= vpack[DATA_W-1:0];
      side_v.vsat  <= vpack[DATA_W];
      side_v.dam   <= DATA_W'(g_h >> (31 - FRAC_BITS));
    end
  end

  // Centre derivative magnitudes
  gm2g_ddiv u_ddiv_u (.clk(clk), .adv(adv), .num(num_u), .den(wmag_u), .quo(dc_u));
  gm2g_ddiv u_ddiv_v (.clk(clk), .adv(adv), .num(num_v), .den(wmag_v), .quo(dc_v));

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_v;
      for (int i = 1; i < DDIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Stage M: partial products of |d_centre|*|arg|
  always_ff @(posedge clk) begin
    if (adv) begin
      dcm_u  <= dc_u;
      dcm_v  <= dc_v;
      plo_u  <= dc_u[LO_W-1:0] * side_q[DDIV_LAT-1].ax.amag_u;
      phi_u  <= dc_u[NUM_W-1:LO_W] * side_q[DDIV_LAT-1].ax.amag_u;
      plo_v  <= dc_v[LO_W-1:0] * side_q[DDIV_LAT-1].ax.amag_v;
      phi_v  <= dc_v[NUM_W-1:LO_W] * side_q[DDIV_LAT-1].ax.amag_v;
      side_m <= side_q[DDIV_LAT-1];
    end
  end

  // Stage F: width derivatives, signs and saturation
  always_comb begin
    dwf_u   = (NUM_W+AMAG_W+1)'({phi_u, LO_W'(0)}) + (NUM_W+AMAG_W+1)'(plo_u);
    dwf_v   = (NUM_W+AMAG_W+1)'({phi_v, LO_W'(0)}) + (NUM_W+AMAG_W+1)'(plo_v);
    dneg_u  = hneg ^ side_m.ax.aneg_u ^ wneg_u;
    dneg_v  = hneg ^ side_m.ax.aneg_v ^ wneg_v;
    p_cu    = sat_pack(dneg_u, PACK_W'(dcm_u));
    p_cv    = sat_pack(dneg_v, PACK_W'(dcm_v));
    p_du    = sat_pack(!dneg_u, PACK_W'(dcm_u));
    p_dv    = sat_pack(!dneg_v, PACK_W'(dcm_v));
    p_wu    = sat_pack(hneg ^ wneg_u, PACK_W'(dwf_u >> FRAC_BITS));
    p_wv    = sat_pack(hneg ^ wneg_v, PACK_W'(dwf_v >> FRAC_BITS));
    any_sat = side_m.vsat || p_cu[DATA_W] || p_cv[DATA_W] || p_du[DATA_W] ||
              p_dv[DATA_W] || p_wu[DATA_W] || p_wv[DATA_W];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wz) begin
        out_data        <= '0;
        out_data.status <= ST_ZERO_WIDTH;
      end else begin
        out_data.value       <= side_m.value;
        out_data.d_centre_u  <= p_cu[DATA_W-1:0];
        out_data.d_centre_v  <= p_cv[DATA_W-1:0];
        out_data.d_width_u   <= p_wu[DATA_W-1:0];
        out_data.d_width_v   <= p_wv[DATA_W-1:0];
        out_data.d_amplitude <= side_m.dam;
        out_data.d_u         <= p_du[DATA_W-1:0];
        out_data.d_v         <= p_dv[DATA_W-1:0];
        out_data.status      <= any_sat ? ST_SAT : ST_OK;
      end
    end
  end

  // Input is held back only while a finished result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
                   out_data.status == ST_ZERO_WIDTH))
    else $error("undefined status code");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_ZERO_WIDTH) |->
      (out_data.value == '0 && out_data.d_amplitude == '0 && out_data.d_u == '0))
    else $error("zero width result not cleared");

  a_du_mirror: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_OK) |->
      (out_data.d_u == DATA_W'(-out_data.d_centre_u) &&
       out_data.d_v == DATA_W'(-out_data.d_centre_v)))
    else $error("coordinate derivative does not mirror centre derivative");

  a_damp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.d_amplitude <= (DATA_W'(1) << FRAC_BITS)))
    else $error("amplitude derivative above one");

endmodule
